// ===== rtl/ntpm_pkg.sv =====
`default_nettype none

package ntpm_pkg;

    // Polynomial size and torus word width
    localparam int POLY_DEGREE = 1024;
    localparam int TORUS_BITS  = 32;

    // Ring position and sequencer counter widths
    localparam int IDX_W = (POLY_DEGREE > 2) ? $clog2(POLY_DEGREE) : 1;
    localparam int CNT_W = $clog2(POLY_DEGREE + 2);

    // Item field widths
    localparam int OP_W    = 2;
    localparam int INDEX_W = 10;
    localparam int INT_W   = 32;
    localparam int TCOEF_W = 32;
    localparam int RES_W   = 32;

    localparam int S_TDATA_W = ((INDEX_W + INT_W + TCOEF_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RES_W + INDEX_W + 7) / 8) * 8;

    typedef logic [OP_W-1:0]       op_t;
    typedef logic [TORUS_BITS-1:0] torus_t;

    localparam op_t OP_LOAD  = 2'd0;
    localparam op_t OP_ACC   = 2'd1;
    localparam op_t OP_READ  = 2'd2;
    localparam op_t OP_CLEAR = 2'd3;

    // Control broadcast to every cell of the accumulator ring
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ntpm_ram.sv =====
`default_nettype none

module ntpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/ntpm_cell.sv =====
`default_nettype none

module ntpm_cell (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ntpm_pkg::cell_ctrl_t  ctrl,
    input  wire ntpm_pkg::torus_t      d_in,
    output ntpm_pkg::torus_t           q
);

    ntpm_pkg::torus_t acc_reg;

    // One accumulator; clear zeroes it, else advance to the neighbor on shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (ctrl.shift) begin
            acc_reg <= d_in;
        end
    end

    assign q = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/ntpm_mac.sv =====
`default_nettype none

module ntpm_mac (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          issue,
    input  wire logic                          wrap_in,
    input  wire logic [ntpm_pkg::IDX_W-1:0]    k_in,
    input  wire logic [ntpm_pkg::INT_W-1:0]    a_coef,
    input  wire ntpm_pkg::torus_t              t_val,
    input  wire logic                          acc_mode,
    input  wire ntpm_pkg::torus_t              head,
    output ntpm_pkg::torus_t                   feedback,
    output logic                               shift_en,
    output logic [ntpm_pkg::IDX_W-1:0]         k_out
);

    logic                       v1_reg, v2_reg;
    logic                       wrap1_reg, wrap2_reg;
    logic [ntpm_pkg::IDX_W-1:0] k1_reg, k2_reg;
    ntpm_pkg::torus_t           a_ext;
    ntpm_pkg::torus_t           prod_next, prod_reg;

    // Sign-extend the integer coefficient into torus width; keep low bits of product
    assign a_ext     = ntpm_pkg::torus_t'($signed(a_coef));
    assign prod_next = a_ext * t_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        wrap1_reg <= wrap_in;
        k1_reg    <= k_in;
        wrap2_reg <= wrap1_reg;
        k2_reg    <= k1_reg;
        prod_reg  <= prod_next;
    end

    always_comb begin
        if (!acc_mode) begin
            feedback = head;
        end else if (wrap2_reg) begin
            feedback = head - prod_reg;
        end else begin
            feedback = head + prod_reg;
        end
    end

    assign shift_en = v2_reg;
    assign k_out    = k2_reg;

endmodule

`default_nettype wire

// ===== rtl/negacyclic_torus_poly_multiply_unit.sv =====
`default_nettype none

// Channel   Dir  Fields (tdata low bit up)                          tuser
// s_ items  in   coef_index[9:0] int_coef[41:10] torus_coef[73:42]  op[1:0]
// m_ items  out  result_coef[31:0] result_index[41:32]              op_done[0]
//
// Load, clear and out-of-range items skip the ring and go straight to the output stage.
// Accumulate and read items pass over every cell; the accumulator ring rotates
// one cell per cycle past the single multiply-accumulate unit at its head.
// Reset zeroes all accumulators and control; the coefficient RAM is not cleared.
// A stalled m_tready holds the finished item in the output register while the next
// item is taken; a second finished item waits until the register frees up.

module negacyclic_torus_poly_multiply_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ntpm_pkg::S_TDATA_W-1:0]    s_tdata,   // coef_index, int_coef, torus_coef
    input  wire logic [ntpm_pkg::OP_W-1:0]         s_tuser,   // op
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ntpm_pkg::M_TDATA_W-1:0]         m_tdata,   // result_coef, result_index
    output logic [0:0]                             m_tuser    // op_done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam int IW = ntpm_pkg::IDX_W;
    localparam int N  = ntpm_pkg::POLY_DEGREE;

    // Input field unpacking
    logic [ntpm_pkg::INDEX_W-1:0] s_idx;
    logic [ntpm_pkg::INT_W-1:0]   s_int;
    logic [ntpm_pkg::TCOEF_W-1:0] s_tcoef;
    ntpm_pkg::op_t                s_op;

    assign s_idx   = s_tdata[ntpm_pkg::INDEX_W-1:0];
    assign s_int   = s_tdata[ntpm_pkg::INDEX_W +: ntpm_pkg::INT_W];
    assign s_tcoef = s_tdata[ntpm_pkg::INDEX_W + ntpm_pkg::INT_W +: ntpm_pkg::TCOEF_W];
    assign s_op    = s_tuser;

    logic           accept;
    logic           in_range;
    logic [IW-1:0]  s_addr;

    assign accept   = s_tvalid && s_tready;
    assign in_range = (32'(s_idx) < N);
    assign s_addr   = IW'(s_idx);

    // Control and item registers
    logic [1:0]                      state_reg, state_next;
    logic [ntpm_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    ntpm_pkg::op_t                   op_reg;
    logic [ntpm_pkg::INDEX_W-1:0]    idx_reg;
    logic [IW-1:0]                   addr_reg;
    logic                            done_reg;
    ntpm_pkg::torus_t                tval_reg;
    logic [ntpm_pkg::RES_W-1:0]      coef_reg;

    logic                            m_tvalid_reg;
    logic [ntpm_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                            m_tuser_reg;
    logic                            out_load;

    // Sequencer address generation: j = (k - i) mod N, wrapped when k < i
    logic           issue;
    logic [IW-1:0]  cnt_low;
    logic           wrap;
    logic [IW:0]    addr_wide;
    logic [IW-1:0]  raddr;

    assign issue     = (state_reg == ST_RUN) && (32'(cnt_reg) < N);
    assign cnt_low   = cnt_reg[IW-1:0];
    assign wrap      = cnt_low < addr_reg;
    assign addr_wide = wrap ? ({1'b0, cnt_low} + (IW+1)'(N) - {1'b0, addr_reg})
                            : ({1'b0, cnt_low} - {1'b0, addr_reg});
    assign raddr     = addr_wide[IW-1:0];

    // Integer coefficient store
    logic [ntpm_pkg::INT_W-1:0] a_coef;

    ntpm_ram #(
        .WIDTH (ntpm_pkg::INT_W),
        .DEPTH (N)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (accept && (s_op == ntpm_pkg::OP_LOAD) && in_range),
        .waddr (s_addr),
        .wdata (s_int),
        .raddr (raddr),
        .rdata (a_coef)
    );

    // Multiply-accumulate at the head of the ring
    ntpm_pkg::torus_t           head;
    ntpm_pkg::torus_t           feedback;
    logic                       shift_en;
    logic [IW-1:0]              k_out;
    logic                       acc_mode;

    assign acc_mode = (op_reg == ntpm_pkg::OP_ACC);

    ntpm_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .issue    (issue),
        .wrap_in  (wrap),
        .k_in     (cnt_low),
        .a_coef   (a_coef),
        .t_val    (tval_reg),
        .acc_mode (acc_mode),
        .head     (head),
        .feedback (feedback),
        .shift_en (shift_en),
        .k_out    (k_out)
    );

    // Accumulator ring: cell 0 is the head, the tail takes the updated head value
    ntpm_pkg::cell_ctrl_t cell_ctrl;
    ntpm_pkg::torus_t     cell_q [N];

    assign cell_ctrl.shift = shift_en;
    assign cell_ctrl.clear = accept && (s_op == ntpm_pkg::OP_CLEAR);
    assign head            = cell_q[0];

    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == N - 1) begin : g_tail
            ntpm_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (cell_ctrl),
                .d_in    (feedback),
                .q       (cell_q[g])
            );
        end else begin : g_body
            ntpm_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (cell_ctrl),
                .d_in    (cell_q[g+1]),
                .q       (cell_q[g])
            );
        end
    end

    // State machine
    assign out_load = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next = '0;
                    if (in_range && (s_op == ntpm_pkg::OP_ACC || s_op == ntpm_pkg::OP_READ)) begin
                        state_next = ST_RUN;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_RUN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ntpm_pkg::CNT_W'(N + 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Latch the item on accept; capture the addressed accumulator as it passes the head
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_op;
            idx_reg  <= s_idx;
            addr_reg <= s_addr;
            done_reg <= (s_op == ntpm_pkg::OP_CLEAR) || in_range;
            tval_reg <= ntpm_pkg::torus_t'(s_tcoef);
            coef_reg <= '0;
        end else if (shift_en && !acc_mode && (k_out == addr_reg)) begin
            coef_reg <= ntpm_pkg::RES_W'(head);
        end
    end

    // Output register
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[ntpm_pkg::RES_W-1:0] = coef_reg;
        m_tdata_next[ntpm_pkg::RES_W +: ntpm_pkg::INDEX_W] = idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= done_reg;
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire

// ===== rtl/ntpm_checker.sv =====
`default_nettype none

module ntpm_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [ntpm_pkg::S_TDATA_W-1:0]    s_tdata,
    input wire logic [ntpm_pkg::OP_W-1:0]         s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [ntpm_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic [0:0]                        m_tuser
);

    // No result item straight out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item valid after reset");

    // A stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

    // Each accepted item blocks the input on the following cycle
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A refused op carries a zero coefficient
    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata[ntpm_pkg::RES_W-1:0] == '0))
        else $error("refused op returned nonzero coefficient");

endmodule

bind negacyclic_torus_poly_multiply_unit ntpm_checker u_ntpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/negacyclic_torus_poly_multiply_unit_test.sv =====
`timescale 1ns / 1ps

module negacyclic_torus_poly_multiply_unit_test;

    import ntpm_pkg::*;

    // Receiver stall patterns
    localparam int STALL_NONE = 0;
    localparam int STALL_COIN = 1;
    localparam int STALL_LONG = 2;

    // Guard against a hung block; far above the slowest legal run
    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int RANDOM_ITEMS = 580;

    // Tracks the integer coefficients and the torus accumulator ring, and holds
    // the results the block still owes, oldest first.
    class poly_product_model;
        typedef struct {
            torus_t             coef;
            logic [INDEX_W-1:0] index;
            logic               done;
        } result_t;

        logic [INT_W-1:0] int_coef_ram [POLY_DEGREE];
        torus_t           acc_ring [POLY_DEGREE];
        result_t          pending_results [$];
        int               mismatches;

        function new();
            foreach (int_coef_ram[k]) int_coef_ram[k] = '0;
            foreach (acc_ring[k]) acc_ring[k] = '0;
            mismatches = 0;
        endfunction

        task report_mismatch(string what);
            if (mismatches < 40) $display("mismatch: %s", what);
            mismatches++;
        endtask

        // Apply one accepted item and queue the result it must produce.
        function void take_item(op_t op, logic [INDEX_W-1:0] idx,
                                logic [INT_W-1:0] ival, torus_t tval);
            result_t r;
            torus_t  prod;
            int      j;
            int      k;
            r.coef  = '0;
            r.index = idx;
            r.done  = 1'b1;
            if (op == OP_CLEAR) begin
                foreach (acc_ring[n]) acc_ring[n] = '0;
            end else if (int'(idx) >= POLY_DEGREE) begin
                r.done = 1'b0;
            end else if (op == OP_LOAD) begin
                int_coef_ram[idx] = ival;
            end else if (op == OP_ACC) begin
                for (j = 0; j < POLY_DEGREE; j++) begin
                    prod = torus_t'($signed(int_coef_ram[j])) * tval;
                    k = int'(idx) + j;
                    // wrapping past X^N flips the sign
                    if (k >= POLY_DEGREE)
                        acc_ring[k - POLY_DEGREE] -= prod;
                    else
                        acc_ring[k] += prod;
                end
            end else begin
                r.coef = acc_ring[idx];
            end
            pending_results.push_back(r);
        endfunction

        task match_result(torus_t coef, logic [INDEX_W-1:0] idx, logic done);
            result_t r;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result coef=%h index=%0d done=%b",
                                          coef, idx, done));
            end else begin
                r = pending_results.pop_front();
                if (coef !== r.coef)
                    report_mismatch($sformatf("index %0d: result_coef %h, want %h",
                                              r.index, coef, r.coef));
                if (idx !== r.index)
                    report_mismatch($sformatf("result_index %0d, want %0d", idx, r.index));
                if (done !== r.done)
                    report_mismatch($sformatf("index %0d: op_done %b, want %b",
                                              r.index, done, r.done));
            end
        endtask
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    poly_product_model products = new();

    int cycles     = 0;
    int burst_left = 0;
    int stall_mode = STALL_NONE;
    int mode_left  = 0;
    int hold_left  = 0;

    negacyclic_torus_poly_multiply_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // coef_index, int_coef, torus_coef
        .s_tuser  (s_tuser),   // op
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // result_coef, result_index
        .m_tuser  (m_tuser)    // op_done
    );

    always #10 aclk = ~aclk;

    // End the run if the block stops making progress.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: switch between always ready, coin-flip ready and long stalls,
    // each for a stretch of random length.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            mode_left  <= $urandom_range(50, 400);
            stall_mode <= $urandom_range(STALL_NONE, STALL_LONG);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            STALL_NONE: begin
                m_tready <= 1'b1;
            end
            STALL_COIN: begin
                m_tready <= $urandom_range(0, 1);
            end
            default: begin
                // hold low for long runs, release briefly
                if (hold_left == 0) begin
                    m_tready  <= ~m_tready;
                    hold_left <= m_tready ? $urandom_range(1, 30) : $urandom_range(0, 3);
                end else begin
                    hold_left <= hold_left - 1;
                end
            end
        endcase
    end

    // Check every result item as it leaves the block.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            products.match_result(m_tdata[RES_W-1:0], m_tdata[RES_W +: INDEX_W], m_tuser[0]);
    end

    // Signed coefficient with the extremes and small values mixed in.
    function automatic logic [INT_W-1:0] pick_int_coef();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4:       return INT_W'($urandom_range(0, 15) - 8);
            default: return $urandom;
        endcase
    endfunction

    // Present one item, hold it until taken, then record it. Start a gap when
    // the current burst runs out; otherwise leave tvalid high for the next item.
    task automatic push_item(op_t op, logic [INDEX_W-1:0] idx,
                             logic [INT_W-1:0] ival, torus_t tval);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - INDEX_W - INT_W - TCOEF_W){1'b0}}, tval, ival, idx};
        do @(posedge aclk); while (!s_tready);
        products.take_item(op, idx, ival, tval);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // an occasional long gap lands in the middle of an accumulate pass
            gap = ($urandom_range(0, 39) == 0) ? $urandom_range(1, POLY_DEGREE + 80)
                                               : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        int                 n;
        int                 pick;
        op_t                op;
        logic [INDEX_W-1:0] idx;
        logic [INT_W-1:0]   ival;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reads of the freshly reset ring and a clear, before any
        // accumulate is allowed.
        push_item(OP_READ, 10'd0, 32'h0, 32'h0);
        push_item(OP_READ, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(OP_CLEAR, 10'd1023, 32'h0, 32'h0);

        // Load every coefficient before the first accumulate; pin the extremes
        // at both ends of the ring.
        for (n = 0; n < POLY_DEGREE; n++) begin
            case (n)
                0:       ival = 32'h8000_0000;
                1:       ival = 32'h7FFF_FFFF;
                2:       ival = 32'hFFFF_FFFF;
                3:       ival = 32'h0000_0000;
                1023:    ival = 32'h8000_0000;
                default: ival = pick_int_coef();
            endcase
            push_item(OP_LOAD, INDEX_W'(n), ival, $urandom);
        end

        // Directed: accumulate at the first and last positions (the last one
        // wraps nearly every term), torus extremes, reads around the wrap.
        push_item(OP_ACC, 10'd0, 32'h0, 32'h0000_0001);
        push_item(OP_READ, 10'd0, 32'h0, 32'h0);
        push_item(OP_READ, 10'd1023, 32'h0, 32'h0);
        push_item(OP_ACC, 10'd1023, 32'h0, 32'hFFFF_FFFF);
        push_item(OP_READ, 10'd0, 32'h0, 32'h0);
        push_item(OP_READ, 10'd1, 32'h0, 32'h0);
        push_item(OP_ACC, 10'd512, 32'h0, 32'h8000_0000);
        push_item(OP_READ, 10'd511, 32'h0, 32'h0);
        push_item(OP_READ, 10'd512, 32'h0, 32'h0);
        push_item(OP_ACC, 10'd1, 32'h0, 32'h0000_0000);
        push_item(OP_READ, 10'd1022, 32'h0, 32'h0);
        // clear keeps the integer coefficients; accumulate again afterwards
        push_item(OP_CLEAR, 10'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(OP_READ, 10'd1023, 32'h0, 32'h0);
        push_item(OP_LOAD, 10'd5, 32'h7FFF_FFFF, 32'h0);
        push_item(OP_ACC, 10'd3, 32'h0, 32'h7FFF_FFFF);
        push_item(OP_READ, 10'd8, 32'h0, 32'h0);
        push_item(OP_READ, 10'd3, 32'h0, 32'h0);

        // Random mix: loads are cheap, accumulates and reads walk the whole ring.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                op = OP_LOAD;
            else if (pick < 60)
                op = OP_ACC;
            else if (pick < 93)
                op = OP_READ;
            else
                op = OP_CLEAR;
            case ($urandom_range(0, 9))
                0:       idx = '0;
                1:       idx = '1;
                default: idx = $urandom;
            endcase
            push_item(op, idx, pick_int_coef(), $urandom);
        end
        s_tvalid <= 1'b0;

        // Drain, then give a stray extra result time to show up.
        while (products.pending_results.size() != 0) @(posedge aclk);
        repeat (POLY_DEGREE + 16) @(posedge aclk);

        if (products.mismatches == 0 && products.pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
